### rtl/core/xoroshiro128plus_generator_top_macros.svh
// ----------------------------------------------------------------------------
// xoroshiro128plus_generator_top_macros.svh
// Assertion macros used by the generator top.
// ----------------------------------------------------------------------------
`ifndef XOROSHIRO128PLUS_GENERATOR_TOP_MACROS_SVH
`define XOROSHIRO128PLUS_GENERATOR_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define XRS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define XRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/xrs_pkg.sv
// ----------------------------------------------------------------------------
// xrs_pkg
// Types, codes and constants of the xoroshiro128+ generator.
// ----------------------------------------------------------------------------
package xrs_pkg;

    localparam int WORD_W = 64;
    localparam int HALF_W = 32;
    localparam int FRAC_W = 52;
    localparam int FRAC_LSB = WORD_W - FRAC_W;

    // operation codes
    localparam logic [1:0] FUNC_GEN    = 2'd0;
    localparam logic [1:0] FUNC_RESEED = 2'd1;
    localparam logic [1:0] FUNC_JUMP   = 2'd2;

    // SplitMix64 constants
    localparam logic [63:0] GOLDEN_STEP = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] MIX_MUL_ONE = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] MIX_MUL_TWO = 64'h94D0_49BB_1331_11EB;
    localparam int MIX_SHIFT_ONE   = 30;
    localparam int MIX_SHIFT_TWO   = 27;
    localparam int MIX_SHIFT_THREE = 31;

    // xoroshiro128+ step constants
    localparam int ROT_A   = 55;
    localparam int ROT_B   = 36;
    localparam int SHIFT_B = 14;

    // jump polynomial, bit 0 of the low word first
    localparam logic [127:0] JUMP_POLY = {64'hd86b_048b_86aa_9922, 64'hbeac_0467_eba5_facb};
    localparam int JUMP_CNT_W = 7;
    localparam logic [JUMP_CNT_W-1:0] JUMP_LAST = 7'd127;

    // multiplier step codes
    localparam logic [1:0] MUL_LOW     = 2'd0;
    localparam logic [1:0] MUL_CROSS_B = 2'd1;
    localparam logic [1:0] MUL_CROSS_A = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MIX  = 5'b00010,
        ST_MUL1 = 5'b00100,
        ST_MUL2 = 5'b01000,
        ST_JUMP = 5'b10000
    } state_t;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } mul_req_t;

endpackage

### rtl/core/xoroshiro128plus_generator_top.sv
// ----------------------------------------------------------------------------
// xoroshiro128plus_generator_top
// xoroshiro128+ generator with SplitMix64 reseed and 2^64 jump-ahead.
// ----------------------------------------------------------------------------
// A generate word (func 0): the shared step unit forms the sum of the two
// state words, which lands in the output register, and advances the state
// on the same edge, so generate words stream at one per clock while the
// output side keeps up. A reseed word (func 1) runs two SplitMix64 rounds
// through one 32x32 multiplier, three passes per 64-bit product and two
// products per round; the next word is taken only once it is done. A jump
// word (func 2) walks the 128 jump polynomial bits, one step-unit advance
// per cycle, and the next word waits for it likewise. func 3 is taken and
// does nothing.
// Reset leaves both state words zero, so generate returns zero until the
// first reseed. The fraction output is the top 52 bits of value, an
// unsigned 0.52 fixed-point number in [0,1).
// ----------------------------------------------------------------------------
`include "xoroshiro128plus_generator_top_macros.svh"

module xoroshiro128plus_generator_top
    import xrs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        func,
    input  logic [WORD_W-1:0] seed,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [WORD_W-1:0] value,
    output logic [FRAC_W-1:0] fraction
);

    // state words
    logic [WORD_W-1:0] word_a_reg;
    logic [WORD_W-1:0] word_a_next;
    logic [WORD_W-1:0] word_b_reg;
    logic [WORD_W-1:0] word_b_next;

    // jump accumulators and bit counter
    logic [WORD_W-1:0]     ja_reg;
    logic [WORD_W-1:0]     ja_next;
    logic [WORD_W-1:0]     jb_reg;
    logic [WORD_W-1:0]     jb_next;
    logic [JUMP_CNT_W-1:0] jcnt_reg;
    logic [JUMP_CNT_W-1:0] jcnt_next;

    // SplitMix64 accumulator and round flag
    logic [WORD_W-1:0] acc_reg;
    logic [WORD_W-1:0] acc_next;
    logic              round_reg;
    logic              round_next;

    // output register
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [WORD_W-1:0] value_reg;
    logic [WORD_W-1:0] value_next;

    state_t state_reg;
    state_t state_next;

    logic              accept;
    logic [WORD_W-1:0] step_sum;
    logic [WORD_W-1:0] step_a;
    logic [WORD_W-1:0] step_b;
    logic              poly_bit;
    logic [WORD_W-1:0] mix_z;
    logic [WORD_W-1:0] mix_out;
    mul_req_t          mul_req;
    logic              mul_done;
    logic [WORD_W-1:0] mul_product;

    xrs_step u_step (
        .word_a (word_a_reg),
        .word_b (word_b_reg),
        .sum    (step_sum),
        .next_a (step_a),
        .next_b (step_b)
    );

    xrs_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mul_req),
        .done    (mul_done),
        .product (mul_product)
    );

    // only generate needs a free output slot, but all functions wait for it
    assign in_ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    assign poly_bit = JUMP_POLY[jcnt_reg];
    assign mix_z    = mul_product ^ (mul_product >> MIX_SHIFT_TWO);
    assign mix_out  = mul_product ^ (mul_product >> MIX_SHIFT_THREE);

    always_comb
    begin
        state_next     = state_reg;
        word_a_next    = word_a_reg;
        word_b_next    = word_b_reg;
        ja_next        = ja_reg;
        jb_next        = jb_reg;
        jcnt_next      = jcnt_reg;
        acc_next       = acc_reg;
        round_next     = round_reg;
        value_next     = value_reg;
        out_valid_next = out_valid_reg && !out_ready;
        mul_req.start  = 1'b0;
        mul_req.a      = acc_reg ^ (acc_reg >> MIX_SHIFT_ONE);
        mul_req.b      = MIX_MUL_ONE;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (func)
                        FUNC_GEN:
                        begin
                            value_next     = step_sum;
                            out_valid_next = 1'b1;
                            word_a_next    = step_a;
                            word_b_next    = step_b;
                        end
                        FUNC_RESEED:
                        begin
                            acc_next   = seed + GOLDEN_STEP;
                            round_next = 1'b0;
                            state_next = ST_MIX;
                        end
                        FUNC_JUMP:
                        begin
                            ja_next    = '0;
                            jb_next    = '0;
                            jcnt_next  = '0;
                            state_next = ST_JUMP;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_MIX:
            begin
                mul_req.start = 1'b1;
                state_next    = ST_MUL1;
            end
            ST_MUL1:
            begin
                if (mul_done)
                begin
                    mul_req.start = 1'b1;
                    mul_req.a     = mix_z;
                    mul_req.b     = MIX_MUL_TWO;
                    state_next    = ST_MUL2;
                end
            end
            ST_MUL2:
            begin
                if (mul_done)
                begin
                    if (!round_reg)
                    begin
                        word_a_next = mix_out;
                        acc_next    = acc_reg + GOLDEN_STEP;
                        round_next  = 1'b1;
                        state_next  = ST_MIX;
                    end
                    else
                    begin
                        word_b_next = mix_out;
                        state_next  = ST_IDLE;
                    end
                end
            end
            ST_JUMP:
            begin
                if (poly_bit)
                begin
                    ja_next = ja_reg ^ word_a_reg;
                    jb_next = jb_reg ^ word_b_reg;
                end
                jcnt_next = jcnt_reg + JUMP_CNT_W'(1);
                if (jcnt_reg == JUMP_LAST)
                begin
                    word_a_next = ja_next;
                    word_b_next = jb_next;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    word_a_next = step_a;
                    word_b_next = step_b;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            word_a_reg    <= '0;
            word_b_reg    <= '0;
            jcnt_reg      <= '0;
            round_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            word_a_reg    <= word_a_next;
            word_b_reg    <= word_b_next;
            jcnt_reg      <= jcnt_next;
            round_reg     <= round_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ja_reg    <= ja_next;
        jb_reg    <= jb_next;
        acc_reg   <= acc_next;
        value_reg <= value_next;
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign fraction  = value_reg[WORD_W-1:FRAC_LSB];

    `XRS_ASSERT_NOW(a_state_onehot, clk, rst_n, 1'b1, $onehot(state_reg),
        "state register not one-hot")
    `XRS_ASSERT_NEXT(a_gen_result, clk, rst_n, accept && (func == FUNC_GEN),
        out_valid_reg && (state_reg == ST_IDLE), "generate word gave no result")
    `XRS_ASSERT_NOW(a_mul_done_state, clk, rst_n, mul_done,
        (state_reg == ST_MUL1) || (state_reg == ST_MUL2), "multiply finished out of sequence")
    `XRS_ASSERT_NEXT(a_jump_end, clk, rst_n, (state_reg == ST_JUMP) && (jcnt_reg == JUMP_LAST),
        state_reg == ST_IDLE, "jump did not end after last polynomial bit")
    `XRS_ASSERT_NEXT(a_no_result_busy, clk, rst_n, (state_reg != ST_IDLE) && !out_valid_reg,
        !out_valid_reg, "result raised while reseed or jump in progress")

endmodule

### rtl/core/xrs_step.sv
// ----------------------------------------------------------------------------
// xrs_step
// One xoroshiro128+ advance: output sum and next state words.
// ----------------------------------------------------------------------------
module xrs_step
    import xrs_pkg::*;
(
    input  logic [WORD_W-1:0] word_a,
    input  logic [WORD_W-1:0] word_b,
    output logic [WORD_W-1:0] sum,
    output logic [WORD_W-1:0] next_a,
    output logic [WORD_W-1:0] next_b
);

    logic [WORD_W-1:0] mixed;

    always_comb
    begin
        mixed  = word_b ^ word_a;
        sum    = word_a + word_b;
        next_a = {word_a[WORD_W-1-ROT_A:0], word_a[WORD_W-1:WORD_W-ROT_A]}
                 ^ mixed ^ (mixed << SHIFT_B);
        next_b = {mixed[WORD_W-1-ROT_B:0], mixed[WORD_W-1:WORD_W-ROT_B]};
    end

endmodule

### rtl/core/xrs_mul.sv
// ----------------------------------------------------------------------------
// xrs_mul
// 64x64 multiply modulo 2^64 on one 32x32 multiplier, three steps.
// ----------------------------------------------------------------------------
module xrs_mul
    import xrs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  mul_req_t          req,
    output logic              done,
    output logic [WORD_W-1:0] product
);

    logic [WORD_W-1:0] a_reg;
    logic [WORD_W-1:0] b_reg;
    logic [WORD_W-1:0] acc_reg;
    logic [WORD_W-1:0] acc_next;
    logic [1:0]        cnt_reg;
    logic [1:0]        cnt_next;
    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;
    logic [HALF_W-1:0] op_a;
    logic [HALF_W-1:0] op_b;
    logic [WORD_W-1:0] part;

    always_comb
    begin
        op_a = (cnt_reg == MUL_CROSS_A) ? a_reg[WORD_W-1:HALF_W] : a_reg[HALF_W-1:0];
        op_b = (cnt_reg == MUL_CROSS_B) ? b_reg[WORD_W-1:HALF_W] : b_reg[HALF_W-1:0];
        part = {{HALF_W{1'b0}}, op_a} * {{HALF_W{1'b0}}, op_b};
        if (cnt_reg == MUL_LOW)
        begin
            acc_next = part;
        end
        else
        begin
            acc_next = acc_reg + {part[HALF_W-1:0], {HALF_W{1'b0}}};
        end
    end

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            cnt_next  = MUL_LOW;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 2'd1;
            if (cnt_reg == MUL_CROSS_A)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= MUL_LOW;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg <= req.a;
            b_reg <= req.b;
        end
        if (busy_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

### tb/sv/xrs_output_checker.sv
// ----------------------------------------------------------------------------
// xrs_output_checker
// Watches both channels of the xoroshiro128+ generator and checks each output
// word against a predicted draw.
// ----------------------------------------------------------------------------
module xrs_output_checker
    import xrs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [1:0]        func,
    input  logic [WORD_W-1:0] seed,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [WORD_W-1:0] value,
    input  logic [FRAC_W-1:0] fraction,
    output int                fail_count,
    output int                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic [FRAC_W-1:0] fraction;
    } draw_t;

    draw_t             draws_due[$];
    logic [WORD_W-1:0] word_a;
    logic [WORD_W-1:0] word_b;

    // one xoroshiro128+ step on {b, a}
    function automatic logic [2*WORD_W-1:0] xoro_advance(input logic [2*WORD_W-1:0] pair);
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] x;
        a = pair[WORD_W-1:0];
        x = pair[2*WORD_W-1:WORD_W] ^ a;
        return {(x << ROT_B) | (x >> (WORD_W - ROT_B)),
                ((a << ROT_A) | (a >> (WORD_W - ROT_A))) ^ x ^ (x << SHIFT_B)};
    endfunction

    // SplitMix64 output mix of an already advanced accumulator
    function automatic logic [WORD_W-1:0] splitmix_out(input logic [WORD_W-1:0] acc);
        logic [WORD_W-1:0] z;
        z = (acc ^ (acc >> MIX_SHIFT_ONE)) * MIX_MUL_ONE;
        z = (z ^ (z >> MIX_SHIFT_TWO)) * MIX_MUL_TWO;
        return z ^ (z >> MIX_SHIFT_THREE);
    endfunction

    // 2^64 steps ahead: xor of the states picked by the jump polynomial
    function automatic logic [2*WORD_W-1:0] jump_pair(input logic [2*WORD_W-1:0] pair);
        logic [2*WORD_W-1:0] acc;
        logic [2*WORD_W-1:0] cur;
        acc = '0;
        cur = pair;
        for (int i = 0; i < 2*WORD_W; i++)
        begin
            if (JUMP_POLY[i])
                acc ^= cur;
            cur = xoro_advance(cur);
        end
        return acc;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [WORD_W-1:0] sum;
        draw_t             want;
        if (!rst_n)
        begin
            word_a = '0;
            word_b = '0;
            draws_due.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            // input side first, so a same-edge output still pops the oldest draw
            if (in_valid && in_ready)
            begin
                case (func)
                    FUNC_GEN:
                    begin
                        sum = word_a + word_b;
                        draws_due.push_back({sum, sum[WORD_W-1:FRAC_LSB]});
                        {word_b, word_a} = xoro_advance({word_b, word_a});
                    end
                    FUNC_RESEED:
                    begin
                        word_a = splitmix_out(seed + GOLDEN_STEP);
                        word_b = splitmix_out(seed + GOLDEN_STEP + GOLDEN_STEP);
                    end
                    FUNC_JUMP:
                        {word_b, word_a} = jump_pair({word_b, word_a});
                    default:
                        ;   // unused code: no effect
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (draws_due.size() == 0)
                begin
                    $display("%0t: unexpected word, value %h fraction %h",
                             $time, value, fraction);
                    fail_count++;
                end
                else
                begin
                    want = draws_due.pop_front();
                    if (value !== want.value)
                    begin
                        $display("%0t: value mismatch, expected %h actual %h",
                                 $time, want.value, value);
                        fail_count++;
                    end
                    if (fraction !== want.fraction)
                    begin
                        $display("%0t: fraction mismatch, expected %h actual %h",
                                 $time, want.fraction, fraction);
                        fail_count++;
                    end
                end
            end
            pending = draws_due.size();
        end
    end

endmodule

### tb/sv/xoroshiro128plus_generator_top_tb.sv
// ----------------------------------------------------------------------------
// xoroshiro128plus_generator_top_tb
// Stimulus and verdict for the xoroshiro128+ generator.
// ----------------------------------------------------------------------------
// A directed opening covers the all-zero state after reset, jump from zero,
// the unused code, and reseeds with extreme seeds. A random phase follows:
// mostly generate words with reseeds and jumps mixed in, plus a few unused
// codes. Both channel sides draw a random wait per word, with runs of
// back-to-back traffic in between. Checking lives in xrs_output_checker.
// ----------------------------------------------------------------------------
module xoroshiro128plus_generator_top_tb;
    import xrs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         CYCLE_LIMIT  = 1_000_000;
    localparam int         DRAIN_CYCLES = 300;     // covers a jump with margin
    localparam int         RANDOM_WORDS = 930;
    localparam logic [1:0] FUNC_UNUSED  = 2'd3;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    logic [1:0]        func      = FUNC_GEN;
    logic [WORD_W-1:0] seed      = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [WORD_W-1:0] value;
    logic [FRAC_W-1:0] fraction;

    int fail_count;
    int pending;
    int in_calm;

    xoroshiro128plus_generator_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .seed      (seed),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .value     (value),
        .fraction  (fraction)
    );

    xrs_output_checker u_draw_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .seed       (seed),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .value      (value),
        .fraction   (fraction),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Per-word random wait. Now and then a calm stretch of zero waits
    // so the block also sees back-to-back traffic.
    function automatic int pick_wait(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
        begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 9);
    endfunction

    // Seeds lean toward the edges: zero, all ones, one hot; otherwise random.
    function automatic logic [WORD_W-1:0] pick_seed();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return 64'd1 << $urandom_range(0, WORD_W - 1);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Present one word after its idle gap and hold it until accepted.
    // With a zero gap valid simply stays high into the next word.
    task automatic send_word(input logic [1:0] f, input logic [WORD_W-1:0] s);
        int gap;
        gap = pick_wait(in_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        seed     <= s;
        do @(posedge clk); while (!in_ready);
    endtask

    // Output side: stall a random number of cycles per word, then take it.
    initial
    begin
        int stall;
        int out_calm;
        out_calm = 0;
        @(posedge rst_n);
        forever
        begin
            stall = pick_wait(out_calm);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Watchdog
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        int         sent;
        int unsigned pick;
        in_calm = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // all-zero state after reset is a fixed point
        send_word(FUNC_GEN, '1);
        send_word(FUNC_GEN, '0);
        // jump from zero keeps the state zero
        send_word(FUNC_JUMP, {$urandom, $urandom});
        send_word(FUNC_GEN, {$urandom, $urandom});
        // unused code is ignored
        send_word(FUNC_UNUSED, '1);
        send_word(FUNC_GEN, '0);
        // extreme seeds
        send_word(FUNC_RESEED, '0);
        send_word(FUNC_GEN, '0);
        send_word(FUNC_GEN, '1);
        send_word(FUNC_RESEED, '1);
        send_word(FUNC_GEN, '0);
        send_word(FUNC_JUMP, '0);
        send_word(FUNC_GEN, '0);
        send_word(FUNC_GEN, '0);
        send_word(FUNC_UNUSED, {$urandom, $urandom});
        send_word(FUNC_GEN, '0);
        send_word(FUNC_RESEED, 64'h8000_0000_0000_0000);
        send_word(FUNC_GEN, '0);
        send_word(FUNC_RESEED, 64'h0000_0000_0000_0001);
        send_word(FUNC_JUMP, '1);
        send_word(FUNC_JUMP, '0);
        send_word(FUNC_GEN, '0);
        send_word(FUNC_RESEED, {$urandom, $urandom});
        send_word(FUNC_GEN, '0);

        // Random phase: generate dominates; unused codes don't count.
        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 88)
            begin
                send_word(FUNC_GEN, {$urandom, $urandom});
                sent++;
            end
            else if (pick < 95)
            begin
                send_word(FUNC_RESEED, pick_seed());
                sent++;
            end
            else if (pick < 97)
            begin
                send_word(FUNC_JUMP, {$urandom, $urandom});
                sent++;
            end
            else
                send_word(FUNC_UNUSED, {$urandom, $urandom});
        end
        in_valid <= 1'b0;

        // drain: sample on the falling edge, clear of checker updates
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### files.f
+incdir+rtl/core
rtl/core/xrs_pkg.sv
rtl/core/xrs_step.sv
rtl/core/xrs_mul.sv
rtl/core/xoroshiro128plus_generator_top.sv
tb/sv/xrs_output_checker.sv
tb/sv/xoroshiro128plus_generator_top_tb.sv
